// File: hdl/ist_pkg.sv
// ist_pkg: shared types, constants and codes for the integer set table.
// Depends on nothing; every other file refers to it by scoped names.
package ist_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_W     = 32;
	localparam int OP_W       = 3;
	localparam int COUNT_W    = 5;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QFILL_W    = $clog2(QDEPTH + 1);

	// Operation codes as they arrive on the op port.
	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
	localparam logic [OP_W-1:0] OP_LIST   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	typedef enum logic [2:0] {
		K_ADD,
		K_REMOVE,
		K_TEST,
		K_LIST,
		K_CLEAR,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [DATA_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic               found;
		logic               rejected_full;
		logic [DATA_W-1:0]  element;
		logic               element_valid;
		logic [COUNT_W-1:0] count;
		logic               empty_res;
		logic               last;
	} res_t;

	typedef enum logic [1:0] {
		ST_FETCH,
		ST_EXEC,
		ST_LIST
	} state_t;

endpackage

// File: hdl/ist_front.sv
// ist_front: input register stage; accepts transfers and classifies the op code.
// Depends on ist_pkg; feeds ist_queue.
module ist_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ist_pkg::OP_W-1:0]          op,
	input  logic signed [ist_pkg::DATA_W-1:0] value,
	input  logic                              q_full,
	output logic                              q_push,
	output ist_pkg::cmd_t                     q_cmd
);

	logic               valid_s1;
	ist_pkg::cmd_t      cmd_s1;
	ist_pkg::kind_t     kind_d;
	logic               accept;

	always_comb begin
		unique case (op)
			ist_pkg::OP_ADD:    kind_d = ist_pkg::K_ADD;
			ist_pkg::OP_REMOVE: kind_d = ist_pkg::K_REMOVE;
			ist_pkg::OP_TEST:   kind_d = ist_pkg::K_TEST;
			ist_pkg::OP_LIST:   kind_d = ist_pkg::K_LIST;
			ist_pkg::OP_CLEAR:  kind_d = ist_pkg::K_CLEAR;
			default:            kind_d = ist_pkg::K_NOP;
		endcase
	end

	// Hold the stage only while it is full and the queue cannot take it.
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_cmd    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind  <= kind_d;
			cmd_s1.value <= value;
		end
	end

endmodule

// File: hdl/ist_queue.sv
// ist_queue: short command FIFO that decouples the front stage from the execute unit.
// Depends on ist_pkg.
module ist_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ist_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output ist_pkg::cmd_t head
);

	ist_pkg::cmd_t                  slots_q [ist_pkg::QDEPTH];
	logic [ist_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ist_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ist_pkg::QFILL_W-1:0]    fill_q;
	logic                           do_push;
	logic                           do_pop;

	assign full     = fill_q == ist_pkg::QFILL_W'(ist_pkg::QDEPTH);
	assign nonempty = fill_q != '0;
	assign head     = slots_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	function automatic logic [ist_pkg::QPTR_W-1:0] next_ptr(
		input logic [ist_pkg::QPTR_W-1:0] p
	);
		logic [ist_pkg::QPTR_W-1:0] r;
		if (p == ist_pkg::QPTR_W'(ist_pkg::QDEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + ist_pkg::QPTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + ist_pkg::QFILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - ist_pkg::QFILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hdl/ist_back.sv
// ist_back: execute unit; holds the compacted store, runs each command and
// drives the result register. Depends on ist_pkg; takes commands from ist_queue.
module ist_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ist_pkg::cmd_t q_head,
	input  logic          q_nonempty,
	output logic          q_pop,
	input  logic          out_stall,
	output logic          out_valid,
	output ist_pkg::res_t res
);

	ist_pkg::state_t              state_q, state_d;
	logic [ist_pkg::DATA_W-1:0]   entries_q [ist_pkg::CAPACITY];
	logic [ist_pkg::CNT_W-1:0]    cnt_q;
	logic [ist_pkg::CNT_W-1:0]    cnt_new;
	logic [ist_pkg::IDX_W-1:0]    idx_q;
	ist_pkg::cmd_t                cur_q;
	logic [ist_pkg::CAPACITY-1:0] match_q, match_d, ge;
	logic                         found_w, cnt_full, out_free, list_end;
	logic                         emit, do_add, do_remove, do_clear, list_start, list_step;
	logic                         out_valid_q;
	ist_pkg::res_t                res_q, res_d;

	// Compare the queue head against every live entry; registered on pop.
	always_comb begin
		for (int i = 0; i < ist_pkg::CAPACITY; i++) begin
			match_d[i] = (entries_q[i] == q_head.value) &&
				(ist_pkg::CNT_W'(i) < cnt_q);
		end
	end

	// Entries at and above the match move down one place on remove.
	always_comb begin
		ge[0] = match_q[0];
		for (int i = 1; i < ist_pkg::CAPACITY; i++) begin
			ge[i] = ge[i-1] | match_q[i];
		end
	end

	assign found_w  = |match_q;
	assign cnt_full = cnt_q == ist_pkg::CNT_W'(ist_pkg::CAPACITY);
	assign out_free = !out_valid_q || !out_stall;
	assign list_end = (ist_pkg::CNT_W'(idx_q) + ist_pkg::CNT_W'(1)) == cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ist_pkg::ST_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		emit       = 1'b0;
		do_add     = 1'b0;
		do_remove  = 1'b0;
		do_clear   = 1'b0;
		list_start = 1'b0;
		list_step  = 1'b0;
		res_d      = '0;
		unique case (state_q)
			ist_pkg::ST_FETCH: begin
				if (q_nonempty) begin
					q_pop   = 1'b1;
					state_d = ist_pkg::ST_EXEC;
				end
			end
			ist_pkg::ST_EXEC: begin
				if (cur_q.kind == ist_pkg::K_LIST && cnt_q != '0) begin
					list_start = 1'b1;
					state_d    = ist_pkg::ST_LIST;
				end else if (out_free) begin
					emit       = 1'b1;
					res_d.last = 1'b1;
					state_d    = ist_pkg::ST_FETCH;
					unique case (cur_q.kind)
						ist_pkg::K_ADD: begin
							res_d.found = found_w;
							if (!found_w) begin
								if (cnt_full) begin
									res_d.rejected_full = 1'b1;
								end else begin
									do_add = 1'b1;
								end
							end
						end
						ist_pkg::K_REMOVE: begin
							res_d.found = found_w;
							do_remove   = found_w;
						end
						ist_pkg::K_TEST:  res_d.found = found_w;
						ist_pkg::K_CLEAR: do_clear = 1'b1;
						ist_pkg::K_LIST,
						ist_pkg::K_NOP: begin
						end
						default: begin
						end
					endcase
				end
			end
			ist_pkg::ST_LIST: begin
				if (out_free) begin
					emit                = 1'b1;
					list_step           = 1'b1;
					res_d.element       = entries_q[idx_q];
					res_d.element_valid = 1'b1;
					res_d.last          = list_end;
					if (list_end) begin
						state_d = ist_pkg::ST_FETCH;
					end
				end
			end
			default: state_d = ist_pkg::ST_FETCH;
		endcase

		if (do_add) begin
			cnt_new = cnt_q + ist_pkg::CNT_W'(1);
		end else if (do_remove) begin
			cnt_new = cnt_q - ist_pkg::CNT_W'(1);
		end else if (do_clear) begin
			cnt_new = '0;
		end else begin
			cnt_new = cnt_q;
		end
		res_d.count     = ist_pkg::COUNT_W'(cnt_new);
		res_d.empty_res = cnt_new == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_new;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q   <= q_head;
			match_q <= match_d;
		end
		if (list_start) begin
			idx_q <= '0;
		end else if (list_step) begin
			idx_q <= idx_q + ist_pkg::IDX_W'(1);
		end
		if (emit) begin
			res_q <= res_d;
		end
		for (int i = 0; i < ist_pkg::CAPACITY; i++) begin
			if (do_add && cnt_q == ist_pkg::CNT_W'(i)) begin
				entries_q[i] <= cur_q.value;
			end else if (do_remove && ge[i] && i < ist_pkg::CAPACITY - 1) begin
				entries_q[i] <= entries_q[(i + 1) % ist_pkg::CAPACITY];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// File: hdl/integer_set_table.sv
// integer_set_table: set of distinct 32-bit integers in a 16-entry compacted store.
// Add, remove, test and clear pass through the front register, the queue, the
// head compare and execute; list emits one result per stored element.
// The fetch/execute loop of the execute unit ends one command before the next;
// a list streams one stored element per unstalled cycle.
// Reset (arst_n low, asynchronous): set empty, queue empty, no result pending.
module integer_set_table (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ist_pkg::OP_W-1:0]          op,
	input  logic signed [ist_pkg::DATA_W-1:0] value,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic                              rejected_full,
	output logic signed [ist_pkg::DATA_W-1:0] element,
	output logic                              element_valid,
	output logic [ist_pkg::COUNT_W-1:0]       count,
	output logic                              empty_res,
	output logic                              last
);

	// Front to queue.
	logic          q_full;
	logic          q_push;
	ist_pkg::cmd_t q_cmd;

	// Queue to execute unit.
	logic          q_pop;
	logic          q_nonempty;
	ist_pkg::cmd_t q_head;

	ist_pkg::res_t res;

	// Front: register each input transfer and turn the op code into a command kind.
	ist_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.value    (value),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	// Queue: lets the front keep taking transfers while the execute unit
	// waits on a stalled result or walks a list.
	ist_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	// Execute unit: parallel compare on pop, then add, remove, test or clear
	// in one step; list streams one stored element per unstalled cycle, oldest first.
	ist_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (q_head),
		.q_nonempty (q_nonempty),
		.q_pop      (q_pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.res        (res)
	);

	// Unpack the result register onto the ports.
	assign found         = res.found;
	assign rejected_full = res.rejected_full;
	assign element       = res.element;
	assign element_valid = res.element_valid;
	assign count         = res.count;
	assign empty_res     = res.empty_res;
	assign last          = res.last;

endmodule

// File: hdl/ist_checker.sv
// ist_checker: port-level assertions for integer_set_table, bound to the top level.
// Depends on ist_pkg for field widths.
module ist_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              found,
	input logic                              rejected_full,
	input logic signed [ist_pkg::DATA_W-1:0] element,
	input logic                              element_valid,
	input logic [ist_pkg::COUNT_W-1:0]       count,
	input logic                              empty_res,
	input logic                              last
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element) && $stable(count) &&
			$stable(last) && $stable(found))
		else $error("stalled result changed");

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (empty_res == (count == '0)))
		else $error("empty flag disagrees with count");

	a_element_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !element_valid |-> element == '0)
		else $error("element nonzero outside a list result");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && rejected_full) && !(element_valid && (found || rejected_full)))
		else $error("conflicting result flags");

	a_list_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && element_valid |-> !empty_res)
		else $error("list element reported from an empty set");

endmodule

bind integer_set_table ist_checker u_ist_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for integer_set_table, with a shadow set predictor.
// Depends on ist_pkg for op codes, sizes and the result record layout.
module tb;

	// Op codes that the block treats as no operation
	localparam logic [ist_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [ist_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam int POOL_N        = 24;
	localparam int RANDOM_ITEMS  = 200;
	localparam int HOLD_AFTER    = 60;   // transfers before the long receiver hold-off
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		logic [ist_pkg::OP_W-1:0]   op;
		logic [ist_pkg::DATA_W-1:0] value;
	} set_request_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [ist_pkg::OP_W-1:0]          op = '0;
	logic signed [ist_pkg::DATA_W-1:0] value = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic                              found;
	logic                              rejected_full;
	logic signed [ist_pkg::DATA_W-1:0] element;
	logic                              element_valid;
	logic [ist_pkg::COUNT_W-1:0]       count;
	logic                              empty_res;
	logic                              last;

	// Shadow copy of the set, updated in transfer order
	logic [ist_pkg::DATA_W-1:0] shadow_store [ist_pkg::CAPACITY];
	int                         shadow_count = 0;

	set_request_t  op_backlog [$];
	ist_pkg::res_t awaited_results [$];
	set_request_t  next_req;

	int          fail_count = 0;
	int          items_accepted = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          stall_draw;
	int          hold_left = 0;
	logic        hold_active = 1'b0;
	logic        hold_done = 1'b0;
	logic [31:0] cyc = '0;

	integer_set_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.rejected_full(rejected_full),
		.element(element),
		.element_valid(element_valid),
		.count(count),
		.empty_res(empty_res),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Idle length for either side: mostly zero or short, now and then long.
	// Idling is off whenever cycle counter bits 7:6 are both zero, a quarter of the time.
	function automatic int idle_len();
		int r;
		if (cyc[7:6] == 2'b00)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void queue_op(logic [ist_pkg::OP_W-1:0] code,
		logic [ist_pkg::DATA_W-1:0] val);
		set_request_t req;
		req.op = code;
		req.value = val;
		op_backlog.push_back(req);
	endfunction

	// Apply one accepted operation to the shadow set and queue the results it causes
	task automatic apply_set_op(input logic [ist_pkg::OP_W-1:0] code,
		input logic [ist_pkg::DATA_W-1:0] val);
		int            hit;
		logic          listed;
		ist_pkg::res_t r;
		hit = -1;
		listed = 1'b0;
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_store[i] == val)
				hit = i;
		r = '0;
		r.last = 1'b1;
		unique case (code)
			ist_pkg::OP_ADD: begin
				if (hit >= 0) begin
					r.found = 1'b1;
				end else if (shadow_count >= ist_pkg::CAPACITY) begin
					r.rejected_full = 1'b1;
				end else begin
					shadow_store[shadow_count] = val;
					shadow_count++;
				end
			end
			ist_pkg::OP_REMOVE: begin
				if (hit >= 0) begin
					// close the gap, keep insertion order
					for (int i = hit; i < shadow_count - 1; i++)
						shadow_store[i] = shadow_store[i + 1];
					shadow_count--;
					r.found = 1'b1;
				end
			end
			ist_pkg::OP_TEST: begin
				r.found = (hit >= 0);
			end
			ist_pkg::OP_LIST: begin
				if (shadow_count > 0) begin
					listed = 1'b1;
					for (int i = 0; i < shadow_count; i++) begin
						r = '0;
						r.element = shadow_store[i];
						r.element_valid = 1'b1;
						r.count = ist_pkg::COUNT_W'(shadow_count);
						r.last = (i == shadow_count - 1);
						awaited_results.push_back(r);
					end
				end
			end
			ist_pkg::OP_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		if (!listed) begin
			r.count = ist_pkg::COUNT_W'(shadow_count);
			r.empty_res = (shadow_count == 0);
			awaited_results.push_back(r);
		end
	endtask

	task automatic check_result();
		ist_pkg::res_t got;
		ist_pkg::res_t want;
		got.found = found;
		got.rejected_full = rejected_full;
		got.element = element;
		got.element_valid = element_valid;
		got.count = count;
		got.empty_res = empty_res;
		got.last = last;
		if (awaited_results.size() == 0) begin
			if (fail_count < 10)
				$display("%0t: result with nothing awaited: elem=%h count=%0d last=%0d",
					$realtime, got.element, got.count, got.last);
			fail_count++;
		end else begin
			want = awaited_results.pop_front();
			if (got !== want) begin
				if (fail_count < 10) begin
					$display("%0t: mismatch expected found=%0d rej=%0d elem=%h ev=%0d cnt=%0d emp=%0d last=%0d",
						$realtime, want.found, want.rejected_full, want.element,
						want.element_valid, want.count, want.empty_res, want.last);
					$display("%0t:          actual   found=%0d rej=%0d elem=%h ev=%0d cnt=%0d emp=%0d last=%0d",
						$realtime, got.found, got.rejected_full, got.element,
						got.element_valid, got.count, got.empty_res, got.last);
				end
				fail_count++;
			end
		end
	endtask

	// Driver: predict on each input transfer, hold a stalled item, then
	// idle out the gap drawn for it before offering the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= '0;
			value <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_set_op(op, value);
				items_accepted <= items_accepted + 1;
			end
			if (in_valid && in_stall) begin
				// hold the stalled payload as it is
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (op_backlog.size() != 0) begin
				next_req = op_backlog.pop_front();
				op <= next_req.op;
				value <= next_req.value;
				in_valid <= 1'b1;
				gap_left <= idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transfer, then draw the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				stall_draw = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
				stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
				out_stall <= hold_active || (stall_draw != 0);
			end
		end
	end

	// Long receiver hold-off, once, while the sender keeps offering:
	// the block's queue fills and it must stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
			hold_active <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				hold_active <= 1'b0;
		end
	end

	initial begin
		logic [ist_pkg::DATA_W-1:0] pool [POOL_N];
		logic                       dup;
		int                         sel;
		int                         directed_n;

		// Value pool: extremes first, then distinct random words, so that
		// adds, removes and tests hit present values often.
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		pool[2] = 32'h0000_0000;
		for (int k = 3; k < POOL_N; k++) begin
			dup = 1'b1;
			while (dup) begin
				pool[k] = $urandom;
				dup = 1'b0;
				for (int j = 0; j < k; j++)
					if (pool[j] == pool[k])
						dup = 1'b1;
			end
		end

		// Directed: empty set, field extremes, duplicates, compaction, spare codes
		queue_op(ist_pkg::OP_LIST, 32'h0);
		queue_op(ist_pkg::OP_TEST, 32'd5);
		queue_op(ist_pkg::OP_REMOVE, 32'd5);
		queue_op(ist_pkg::OP_CLEAR, 32'hFFFF_FFFF);
		queue_op(ist_pkg::OP_ADD, 32'h8000_0000);
		queue_op(ist_pkg::OP_ADD, 32'h7FFF_FFFF);
		queue_op(ist_pkg::OP_ADD, 32'h0000_0000);
		queue_op(ist_pkg::OP_ADD, 32'hFFFF_FFFF);
		queue_op(ist_pkg::OP_ADD, 32'h7FFF_FFFF);
		queue_op(ist_pkg::OP_TEST, 32'h7FFF_FFFF);
		queue_op(ist_pkg::OP_TEST, 32'h0000_0001);
		queue_op(ist_pkg::OP_REMOVE, 32'h0000_0000);
		queue_op(ist_pkg::OP_REMOVE, 32'h0000_0000);
		queue_op(ist_pkg::OP_LIST, 32'h5555_5555);
		for (logic [ist_pkg::OP_W-1:0] c = OP_SPARE_5; c <= OP_SPARE_7 && c != '0; c++)
			queue_op(c, 32'hAAAA_AAAA);
		queue_op(ist_pkg::OP_CLEAR, 32'h0);
		queue_op(ist_pkg::OP_LIST, 32'h0);
		directed_n = op_backlog.size();

		// Random: mostly pool-based operations, with fill-to-full runs
		// and some noise on op and value
		while (op_backlog.size() - directed_n < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				queue_op(ist_pkg::OP_CLEAR, $urandom);
				for (int k = 0; k < ist_pkg::CAPACITY + 2; k++)
					queue_op(ist_pkg::OP_ADD, pool[k]);
				queue_op(ist_pkg::OP_ADD, pool[$urandom_range(0, ist_pkg::CAPACITY - 1)]);
				queue_op(ist_pkg::OP_LIST, $urandom);
				queue_op(ist_pkg::OP_REMOVE, pool[$urandom_range(0, ist_pkg::CAPACITY - 1)]);
				queue_op(ist_pkg::OP_ADD, pool[POOL_N - 1]);
				queue_op(ist_pkg::OP_LIST, $urandom);
			end else if (sel < 40) begin
				queue_op(ist_pkg::OP_ADD, pool[$urandom_range(0, POOL_N - 1)]);
			end else if (sel < 58) begin
				queue_op(ist_pkg::OP_REMOVE, pool[$urandom_range(0, POOL_N - 1)]);
			end else if (sel < 74) begin
				queue_op(ist_pkg::OP_TEST, pool[$urandom_range(0, POOL_N - 1)]);
			end else if (sel < 84) begin
				queue_op(ist_pkg::OP_LIST, $urandom);
			end else if (sel < 86) begin
				queue_op(ist_pkg::OP_CLEAR, $urandom);
			end else if (sel < 88) begin
				queue_op(ist_pkg::OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7)), $urandom);
			end else if (sel < 94) begin
				queue_op(ist_pkg::OP_TEST, $urandom);
			end else begin
				queue_op(ist_pkg::OP_W'($urandom_range(0, 7)), $urandom);
			end
		end

		// Hold reset, then release it at a clock edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every item sent, every awaited result seen
		@(negedge clk);
		while (op_backlog.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		// Wait out the pipeline to catch stray results
		repeat (DRAIN_CYCLES) @(negedge clk);
		fail_count += awaited_results.size();

		if (fail_count == 0)
			$display("PASS integer_set_table");
		else
			$display("FAIL integer_set_table");
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("FAIL integer_set_table");
		$finish;
	end

endmodule
